FILE: hw/rtl/svm_pkg.sv
// Shared constants, codes and control types for the sample voice mixer.
package svm_pkg;

    localparam int MAX_VOICES     = 16;
    localparam int SAMPLE_WORDS   = 65536;
    localparam int SAMPLE_BITS    = 16;

    localparam int VOICE_IDX_BITS = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int COUNT_BITS     = $clog2(MAX_VOICES + 1);
    localparam int ADDR_BITS      = $clog2(SAMPLE_WORDS);
    localparam int POS_BITS       = 17;
    localparam int GAIN_BITS      = 16;
    localparam int DELAY_BITS     = 16;
    localparam int IN_ADDR_BITS   = 16;
    localparam int FRAC_BITS      = 14;
    localparam int MIX_BITS       = 16;
    localparam int BUSY_BITS      = 5;
    localparam int ASUM_BITS      = ((ADDR_BITS > POS_BITS) ? ADDR_BITS : POS_BITS) + 1;
    localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS       = PROD_BITS + VOICE_IDX_BITS + 1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VISIT,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                      wr;
        logic                      trig;
        logic                      tick_start;
        logic                      visit;
        logic [VOICE_IDX_BITS-1:0] voice;
        logic                      finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_status;

endpackage

FILE: hw/rtl/sample_voice_mixer.sv
// Top level of the polyphonic sample player and voice mixer.
//
//  channel   dir  tuser        tdata
//  s_axis    in   op (2)       mem_address, mem_data, sample_length, voice_gain_in, start_delay
//  m_axis    out  clipped (1)  mix_sample, voices_busy (tick items only)
//
//  Write and trigger items are taken while idle; op 3 is taken and dropped.
//  A tick holds the input for the accepting cycle, one voice a cycle, the two drain
//  states DRAIN_A and DRAIN_B for the read/multiply pipe, and the load; its result
//  is registered at the load.
//  A finished result holds in the output register; the next tick stalls at the load only
//  while that result is waiting. Reset idles the voices, controller and valid flags only.
module sample_voice_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] op
    input  logic [1:0]  i_s_axis_tuser,
    // [15:0] mem_address, [31:16] mem_data, [48:32] sample_length,
    // [64:49] voice_gain_in, [80:65] start_delay, [87:81] zero
    input  logic [87:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] mix_sample, [20:16] voices_busy, [23:21] zero
    output logic [23:0] o_m_axis_tdata,
    // [0] clipped
    output logic        o_m_axis_tuser
);

    svm_pkg::t_dp_cmd    cmd;
    svm_pkg::t_dp_status status;

    logic signed [svm_pkg::MIX_BITS-1:0] mix_sample;
    logic                                clipped;
    logic [svm_pkg::BUSY_BITS-1:0]       voices_busy;

    // Sequence the operations; the datapath only follows its commands.
    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_op       (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Unpack the input item straight into the datapath.
    svm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mem_address   (i_s_axis_tdata[15:0]),
        .i_mem_data      ($signed(i_s_axis_tdata[31:16])),
        .i_sample_length (i_s_axis_tdata[48:32]),
        .i_voice_gain_in (i_s_axis_tdata[64:49]),
        .i_start_delay   (i_s_axis_tdata[80:65]),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_mix_sample    (mix_sample),
        .o_clipped       (clipped),
        .o_voices_busy   (voices_busy)
    );

    // Pack the result item, zero-filled to whole bytes.
    assign o_m_axis_tdata = {3'b000, voices_busy, mix_sample};
    assign o_m_axis_tuser = clipped;

endmodule

FILE: hw/rtl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/svm_ctrl.sv
// Controller: operation decode and voice sequencing for one tick.
module svm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_op,
    output logic                o_in_ready,
    input  svm_pkg::t_dp_status i_status,
    output svm_pkg::t_dp_cmd    o_cmd
);

    svm_pkg::t_state                    r_state, n_state;
    logic [svm_pkg::VOICE_IDX_BITS-1:0] r_voice, n_voice;
    logic                               last_voice;

    assign last_voice =
        (r_voice == svm_pkg::VOICE_IDX_BITS'(svm_pkg::MAX_VOICES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svm_pkg::ST_IDLE;
            r_voice <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_voice          = r_voice;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.voice      = r_voice;
        case (r_state)
            svm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_voice    = '0;
                if (i_in_valid) begin
                    case (i_op)
                        svm_pkg::OP_WRITE:   o_cmd.wr   = 1'b1;
                        svm_pkg::OP_TRIGGER: o_cmd.trig = 1'b1;
                        svm_pkg::OP_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = svm_pkg::ST_VISIT;
                        end
                        default: ;
                    endcase
                end
            end
            svm_pkg::ST_VISIT: begin
                o_cmd.visit = 1'b1;
                n_voice     = r_voice + svm_pkg::VOICE_IDX_BITS'(1);
                if (last_voice) begin
                    n_voice = '0;
                    n_state = svm_pkg::ST_DRAIN_A;
                end
            end
            svm_pkg::ST_DRAIN_A: n_state = svm_pkg::ST_DRAIN_B;
            svm_pkg::ST_DRAIN_B: n_state = svm_pkg::ST_DONE;
            svm_pkg::ST_DONE: begin
                if (!i_status.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = svm_pkg::ST_IDLE;
                end
            end
            default: n_state = svm_pkg::ST_IDLE;
        endcase
    end

    a_last_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svm_pkg::ST_VISIT && last_voice) |=> (r_state == svm_pkg::ST_DRAIN_A))
        else $error("last voice visit not followed by drain");

    a_finish_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_status.out_full)
        else $error("result loaded over a waiting result");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != svm_pkg::ST_IDLE) |-> !o_in_ready)
        else $error("input taken while a tick is running");

endmodule

FILE: hw/rtl/svm_dp.sv
// Datapath: voice table, sample memory, multiply-accumulate and output register.
module svm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  svm_pkg::t_dp_cmd                     i_cmd,
    output svm_pkg::t_dp_status                  o_status,
    input  logic [svm_pkg::IN_ADDR_BITS-1:0]     i_mem_address,
    input  logic signed [15:0]                   i_mem_data,
    input  logic [svm_pkg::POS_BITS-1:0]         i_sample_length,
    input  logic [svm_pkg::GAIN_BITS-1:0]        i_voice_gain_in,
    input  logic [svm_pkg::DELAY_BITS-1:0]       i_start_delay,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [svm_pkg::MIX_BITS-1:0]  o_mix_sample,
    output logic                                 o_clipped,
    output logic [svm_pkg::BUSY_BITS-1:0]        o_voices_busy
);

    logic [svm_pkg::MAX_VOICES-1:0]    r_active;
    logic [svm_pkg::IN_ADDR_BITS-1:0]  r_start [svm_pkg::MAX_VOICES];
    logic [svm_pkg::POS_BITS-1:0]      r_length [svm_pkg::MAX_VOICES];
    logic [svm_pkg::POS_BITS-1:0]      r_pos [svm_pkg::MAX_VOICES];
    logic [svm_pkg::GAIN_BITS-1:0]     r_gain [svm_pkg::MAX_VOICES];
    logic [svm_pkg::DELAY_BITS-1:0]    r_delay [svm_pkg::MAX_VOICES];

    logic [svm_pkg::VOICE_IDX_BITS-1:0] free_voice;
    logic [svm_pkg::COUNT_BITS-1:0]     busy_count;

    logic                               cur_active, cur_wait, cur_sound;
    logic [svm_pkg::POS_BITS-1:0]       cur_pos, next_pos;
    logic [svm_pkg::ASUM_BITS-1:0]      rd_sum, wr_sum;
    logic [svm_pkg::SAMPLE_BITS-1:0]    rdata;

    logic                                  r_s1_valid, r_s2_valid;
    logic [svm_pkg::GAIN_BITS-1:0]         r_gain1;
    logic signed [svm_pkg::PROD_BITS-1:0]  r_prod;
    logic signed [svm_pkg::ACC_BITS-1:0]   r_acc, shifted;
    logic signed [svm_pkg::MIX_BITS-1:0]   sat_mix;
    logic                                  sat_clip;

    logic                                  r_out_valid;
    logic signed [svm_pkg::MIX_BITS-1:0]   r_out_mix;
    logic                                  r_out_clip;
    logic [svm_pkg::BUSY_BITS-1:0]         r_out_busy;

    // Lowest idle voice; voice 0 when every voice is busy.
    always_comb begin
        free_voice = '0;
        for (int i = svm_pkg::MAX_VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_voice = svm_pkg::VOICE_IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        busy_count = '0;
        for (int i = 0; i < svm_pkg::MAX_VOICES; i++) begin
            busy_count = busy_count + svm_pkg::COUNT_BITS'(r_active[i]);
        end
    end

    assign cur_active = r_active[i_cmd.voice];
    assign cur_pos    = r_pos[i_cmd.voice];
    assign cur_wait   = (r_delay[i_cmd.voice] != '0);
    assign cur_sound  = cur_active && !cur_wait && (cur_pos < r_length[i_cmd.voice]);
    assign next_pos   = cur_sound ? (cur_pos + svm_pkg::POS_BITS'(1)) : cur_pos;
    assign rd_sum     = svm_pkg::ASUM_BITS'(r_start[i_cmd.voice])
                      + svm_pkg::ASUM_BITS'(cur_pos);
    assign wr_sum     = svm_pkg::ASUM_BITS'(i_mem_address);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.trig) begin
            r_active[free_voice] <= 1'b1;
        end else if (i_cmd.visit && cur_active && !cur_wait) begin
            r_active[i_cmd.voice] <= (next_pos < r_length[i_cmd.voice]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig) begin
            r_start[free_voice]  <= i_mem_address;
            r_length[free_voice] <= i_sample_length;
            r_pos[free_voice]    <= '0;
            r_gain[free_voice]   <= i_voice_gain_in;
            r_delay[free_voice]  <= i_start_delay;
        end else if (i_cmd.visit && cur_active) begin
            if (cur_wait) begin
                r_delay[i_cmd.voice] <= r_delay[i_cmd.voice] - svm_pkg::DELAY_BITS'(1);
            end else begin
                r_pos[i_cmd.voice] <= next_pos;
            end
        end
    end

    svm_ram #(
        .WIDTH (svm_pkg::SAMPLE_BITS),
        .DEPTH (svm_pkg::SAMPLE_WORDS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (wr_sum[svm_pkg::ADDR_BITS-1:0]),
        .i_wdata (svm_pkg::SAMPLE_BITS'(i_mem_data)),
        .i_re    (i_cmd.visit && cur_sound),
        .i_raddr (rd_sum[svm_pkg::ADDR_BITS-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.visit && cur_sound;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain1 <= r_gain[i_cmd.voice];
        r_prod  <= $signed(rdata) * $signed({1'b0, r_gain1});
        if (i_cmd.tick_start) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= r_acc + svm_pkg::ACC_BITS'(r_prod);
        end
    end

    // Floor shift, then clamp to the 16-bit range.
    assign shifted = r_acc >>> svm_pkg::FRAC_BITS;

    always_comb begin
        sat_clip = 1'b1;
        if (shifted > svm_pkg::ACC_BITS'(32767)) begin
            sat_mix = 16'sh7fff;
        end else if (shifted < -(svm_pkg::ACC_BITS'(32768))) begin
            sat_mix = 16'sh8000;
        end else begin
            sat_mix  = shifted[svm_pkg::MIX_BITS-1:0];
            sat_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_mix  <= sat_mix;
            r_out_clip <= sat_clip;
            r_out_busy <= svm_pkg::BUSY_BITS'(busy_count);
        end
    end

    assign o_status.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_mix_sample      = r_out_mix;
    assign o_clipped         = r_out_clip;
    assign o_voices_busy     = r_out_busy;

    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(r_s1_valid))
        else $error("product stage valid without a read");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_mix == 16'sh7fff || r_out_mix == 16'sh8000))
        else $error("clipped result not at a rail");

    a_busy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_busy <= svm_pkg::BUSY_BITS'(svm_pkg::MAX_VOICES)))
        else $error("busy count above voice count");

endmodule
